/* rtl/core/uib_pkg.sv */
// Shared types, codes and sizes of the UART interrupt buffer engine.
package uib_pkg;

    localparam int RX_DEPTH_DEF = 256;
    localparam int TX_DEPTH_DEF = 512;
    localparam int BYTE_W       = 8;
    localparam int LEVEL_W      = 9;

    // Item operations
    localparam logic [1:0] OP_UART_EVENT = 2'd0;
    localparam logic [1:0] OP_HOST_READ  = 2'd1;
    localparam logic [1:0] OP_TX_BLOCK   = 2'd2;
    localparam logic [1:0] OP_DIRECT     = 2'd3;

    // Interrupt identification codes, low nibble
    localparam logic [3:0] IIR_THRE = 4'h2;
    localparam logic [3:0] IIR_RDA  = 4'h4;
    localparam logic [3:0] IIR_RLS  = 4'h6;
    localparam logic [3:0] IIR_CTO  = 4'hC;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        iir_code;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] tx_data;
        logic              block_last;
    } uib_in_t;

    typedef struct packed {
        logic               send_valid;
        logic [BYTE_W-1:0]  send_byte;
        logic               read_valid;
        logic [BYTE_W-1:0]  read_data;
        logic               read_empty;
        logic [LEVEL_W-1:0] rx_level;
        logic               rx_overflow;
    } uib_out_t;

    // Result of one item before the store read data joins it
    typedef struct packed {
        logic               send_valid;
        logic               send_from_ram;
        logic [BYTE_W-1:0]  send_direct;
        logic               read_valid;
        logic               read_empty;
        logic [LEVEL_W-1:0] rx_level;
        logic               rx_overflow;
    } uib_info_t;

endpackage

/* rtl/core/uib_if.sv */
// Valid/ready channel interfaces for items and results.
interface uib_in_if;
    logic             valid;
    logic             ready;
    uib_pkg::uib_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uib_out_if;
    logic              valid;
    logic              ready;
    uib_pkg::uib_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/uart_interrupt_buffer_engine.sv */
// Top level of the UART interrupt buffer engine.
//
// Items enter on req (uart event, host read, transmit block byte, direct
// character) and each gives exactly one result on rsp, in order. A
// transaction completes when valid and ready are both high.
// The result passes through the read stage, where the receive ring or transmit
// store is read through its registered port, and then the result register.
// Throughput: one item per cycle while rsp does not stall, set by the single
// pointer update and at most one write and one read of each store per item.
// When rsp stalls, the result register holds; one more item may be accepted
// into the read stage, after which req.ready drops until rsp takes a result.
// Reset clears the ring pointers, the fill level and the transmit block
// state at once; both stores keep their contents and are only read at
// entries written since reset, so no clearing pass is needed.
module uart_interrupt_buffer_engine #(
    parameter int RX_DEPTH = uib_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = uib_pkg::TX_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    uib_in_if.sink    req,
    uib_out_if.source rsp
);

    localparam int RXA = $clog2(RX_DEPTH);
    localparam int TXA = $clog2(TX_DEPTH);

    logic                       accept;
    logic                       in_ready;
    uib_pkg::uib_info_t         info;
    logic                       rx_we;
    logic [RXA-1:0]             rx_waddr;
    logic                       rx_re;
    logic [RXA-1:0]             rx_raddr;
    logic [uib_pkg::BYTE_W-1:0] rx_rdata;
    logic                       tx_we;
    logic [TXA-1:0]             tx_waddr;
    logic                       tx_re;
    logic [TXA-1:0]             tx_raddr;
    logic [uib_pkg::BYTE_W-1:0] tx_rdata;

    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    uib_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (req.data),
        .rx_we    (rx_we),
        .rx_waddr (rx_waddr),
        .rx_re    (rx_re),
        .rx_raddr (rx_raddr),
        .tx_we    (tx_we),
        .tx_waddr (tx_waddr),
        .tx_re    (tx_re),
        .tx_raddr (tx_raddr),
        .info     (info)
    );

    uib_ram #(
        .WIDTH (uib_pkg::BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (req.data.rx_byte),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    uib_ram #(
        .WIDTH (uib_pkg::BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (req.data.tx_data),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    uib_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .info     (info),
        .rx_rdata (rx_rdata),
        .tx_rdata (tx_rdata),
        .in_ready (in_ready),
        .rsp      (rsp)
    );

endmodule

/* rtl/core/uib_ram.sv */
// Generic simple dual-port RAM with registered read.
module uib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/uib_ctrl.sv */
// Ring and transmit block pointers; decodes each accepted item into store accesses.
module uib_ctrl #(
    parameter int RX_DEPTH = uib_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = uib_pkg::TX_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  uib_pkg::uib_in_t                 item,
    output logic                             rx_we,
    output logic [$clog2(RX_DEPTH)-1:0]      rx_waddr,
    output logic                             rx_re,
    output logic [$clog2(RX_DEPTH)-1:0]      rx_raddr,
    output logic                             tx_we,
    output logic [$clog2(TX_DEPTH)-1:0]      tx_waddr,
    output logic                             tx_re,
    output logic [$clog2(TX_DEPTH)-1:0]      tx_raddr,
    output uib_pkg::uib_info_t               info
);

    localparam int RXA = $clog2(RX_DEPTH);
    localparam int RXC = $clog2(RX_DEPTH + 1);
    localparam int TXA = $clog2(TX_DEPTH);
    localparam int TXC = $clog2(TX_DEPTH + 1);

    logic [RXA-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RXA-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RXC-1:0] rx_count_reg, rx_count_next;
    logic [TXC-1:0] tx_length_reg, tx_length_next;
    logic [TXC-1:0] tx_pos_reg, tx_pos_next;
    logic [TXC-1:0] tx_load_reg, tx_load_next;
    logic [TXC-1:0] load_pos;

    function automatic logic [RXA-1:0] ring_advance(input logic [RXA-1:0] p);
        return (p == RXA'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_count_next  = rx_count_reg;
        tx_length_next = tx_length_reg;
        tx_pos_next    = tx_pos_reg;
        tx_load_next   = tx_load_reg;
        load_pos       = tx_load_reg;
        rx_we    = 1'b0;
        rx_waddr = rx_wr_ptr_reg;
        rx_re    = 1'b0;
        rx_raddr = rx_rd_ptr_reg;
        tx_we    = 1'b0;
        tx_waddr = tx_load_reg[TXA-1:0];
        tx_re    = 1'b0;
        tx_raddr = tx_pos_reg[TXA-1:0];
        info     = '0;

        if (accept)
        begin
            unique case (item.opcode)
                uib_pkg::OP_UART_EVENT:
                begin
                    case (item.iir_code) inside
                        uib_pkg::IIR_THRE:
                        begin
                            if (tx_pos_reg < tx_length_reg)
                            begin
                                info.send_valid    = 1'b1;
                                info.send_from_ram = 1'b1;
                                tx_re              = 1'b1;
                                tx_pos_next        = tx_pos_reg + 1'b1;
                            end
                        end
                        uib_pkg::IIR_RDA, uib_pkg::IIR_RLS, uib_pkg::IIR_CTO:
                        begin
                            if (rx_count_reg < RXC'(RX_DEPTH))
                            begin
                                rx_we          = 1'b1;
                                rx_wr_ptr_next = ring_advance(rx_wr_ptr_reg);
                                rx_count_next  = rx_count_reg + 1'b1;
                            end
                            else
                            begin
                                info.rx_overflow = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                uib_pkg::OP_HOST_READ:
                begin
                    if (rx_count_reg == '0)
                    begin
                        info.read_empty = 1'b1;
                    end
                    else
                    begin
                        info.read_valid = 1'b1;
                        rx_re           = 1'b1;
                        rx_rd_ptr_next  = ring_advance(rx_rd_ptr_reg);
                        rx_count_next   = rx_count_reg - 1'b1;
                    end
                end
                uib_pkg::OP_TX_BLOCK:
                begin
                    // first byte of a block drops what is left of the previous one
                    if (tx_load_reg == '0)
                    begin
                        tx_length_next = '0;
                        tx_pos_next    = '0;
                    end
                    if (tx_load_reg < TXC'(TX_DEPTH))
                    begin
                        tx_we    = 1'b1;
                        load_pos = tx_load_reg + 1'b1;
                    end
                    if (item.block_last)
                    begin
                        tx_length_next  = load_pos;
                        tx_pos_next     = TXC'(1);
                        tx_load_next    = '0;
                        info.send_valid = 1'b1;
                        // a one-byte block is written this cycle: bypass the store
                        if (tx_load_reg == '0)
                        begin
                            info.send_direct = item.tx_data;
                        end
                        else
                        begin
                            info.send_from_ram = 1'b1;
                            tx_re              = 1'b1;
                            tx_raddr           = '0;
                        end
                    end
                    else
                    begin
                        tx_load_next = load_pos;
                    end
                end
                uib_pkg::OP_DIRECT:
                begin
                    info.send_valid  = 1'b1;
                    info.send_direct = item.tx_data;
                end
                default:
                begin
                end
            endcase
        end

        info.rx_level = uib_pkg::LEVEL_W'(rx_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            rx_count_reg  <= '0;
            tx_length_reg <= '0;
            tx_pos_reg    <= '0;
            tx_load_reg   <= '0;
        end
        else
        begin
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_count_reg  <= rx_count_next;
            tx_length_reg <= tx_length_next;
            tx_pos_reg    <= tx_pos_next;
            tx_load_reg   <= tx_load_next;
        end
    end

endmodule

/* rtl/core/uib_out_stage.sv */
// Store-read stage and result register; joins read data to the item's result.
module uib_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  uib_pkg::uib_info_t              info,
    input  logic [uib_pkg::BYTE_W-1:0]      rx_rdata,
    input  logic [uib_pkg::BYTE_W-1:0]      tx_rdata,
    output logic                            in_ready,
    uib_out_if.source                       rsp
);

    logic               s1_valid_reg;
    uib_pkg::uib_info_t s1_reg;
    logic               out_valid_reg;
    uib_pkg::uib_out_t  out_reg;
    uib_pkg::uib_out_t  result;
    logic               advance;

    assign advance  = !out_valid_reg || rsp.ready;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        result.send_valid  = s1_reg.send_valid;
        result.send_byte   = s1_reg.send_from_ram ? tx_rdata : s1_reg.send_direct;
        result.read_valid  = s1_reg.read_valid;
        result.read_data   = s1_reg.read_valid ? rx_rdata : '0;
        result.read_empty  = s1_reg.read_empty;
        result.rx_level    = s1_reg.rx_level;
        result.rx_overflow = s1_reg.rx_overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // hold the stage while the result register is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= info;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

/* rtl/core/uib_checker.sv */
// Port-level checker for the UART interrupt buffer engine, with its bind.
module uib_checker #(
    parameter int RX_DEPTH = uib_pkg::RX_DEPTH_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input uib_pkg::uib_out_t rsp_data
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.send_valid |-> rsp_data.send_byte == '0)
        else $error("send_byte set without send_valid");

    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.read_valid && rsp_data.read_empty)
                      && (rsp_data.read_valid || rsp_data.read_data == '0))
        else $error("inconsistent host read result");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.read_empty |-> rsp_data.rx_level == '0)
        else $error("empty read with nonzero ring level");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.rx_overflow
            |-> rsp_data.rx_level == uib_pkg::LEVEL_W'(RX_DEPTH))
        else $error("overflow reported while ring not full");

endmodule

bind uart_interrupt_buffer_engine uib_checker #(
    .RX_DEPTH (RX_DEPTH)
) u_uib_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
